// ===== rtl/core/ffrt_pkg.sv =====
// Shared constants, types and index helpers for the frame fragment reassembly tracker.
package ffrt_pkg;

  // Sizing of the tracker.
  localparam int WINDOW      = 3;
  localparam int FEC_RECORDS = 10;
  localparam int MAX_PARTS   = 255;
  localparam int SLOTS       = 5;

  // One seen bit per possible fragment index, one row per slot.
  localparam int ROW_W  = 256;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LEN_W  = $clog2(SLOTS + 1);
  localparam int FEC_W  = (FEC_RECORDS > 1) ? $clog2(FEC_RECORDS) : 1;
  localparam int FLEN_W = $clog2(FEC_RECORDS + 1);

  // Result kinds.
  typedef enum logic [3:0] {
    KIND_ADDED     = 4'd0,
    KIND_NEW       = 4'd1,
    KIND_FEC_STORE = 4'd2,
    KIND_MISMATCH  = 4'd3,
    KIND_INDEX_BAD = 4'd4,
    KIND_LATE      = 4'd5,
    KIND_COUNT_BIG = 4'd6,
    KIND_RELEASED  = 4'd7,
    KIND_LOST      = 4'd8,
    KIND_FEC_DROP  = 4'd9
  } kind_t;

  // One result item, without its last flag.
  typedef struct packed {
    kind_t        kind;
    logic [31:0]  seq;
    logic [31:0]  ftime;
    logic [7:0]   parts;
    logic         key;
    logic [15:0]  rot;
  } res_t;

  // Result producer to output stage.
  typedef struct packed {
    logic valid;
    logic flush;
    res_t res;
  } prod_t;

  // Physical slot of a position in the pending ring.
  function automatic logic [SLOT_W-1:0] slot_ring(input logic [SLOT_W-1:0] base,
                                                  input logic [LEN_W-1:0] off);
    logic [LEN_W:0] sum;
    sum = LEN_W'(base) + off;
    if (sum >= (LEN_W + 1)'(SLOTS)) begin
      sum = sum - (LEN_W + 1)'(SLOTS);
    end
    return sum[SLOT_W-1:0];
  endfunction

  // Physical entry of a position in the FEC record ring.
  function automatic logic [FEC_W-1:0] fec_ring(input logic [FEC_W-1:0] base,
                                                input logic [FLEN_W-1:0] off);
    logic [FLEN_W:0] sum;
    sum = FLEN_W'(base) + off;
    if (sum >= (FLEN_W + 1)'(FEC_RECORDS)) begin
      sum = sum - (FLEN_W + 1)'(FEC_RECORDS);
    end
    return sum[FEC_W-1:0];
  endfunction

endpackage

// ===== rtl/core/ffrt_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module ffrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/ffrt_cover.sv =====
// Shared sequence compare unit: does an FEC record cover a given frame.
module ffrt_cover (
  input  logic [31:0] head_seq,
  input  logic [31:0] fec_seq,
  input  logic [7:0]  fec_span,
  output logic        hit
);

  logic [31:0] low_bound;

  // The record covers frames in the range (fec_seq - span, fec_seq].
  assign low_bound = fec_seq - 32'(fec_span);
  assign hit       = (head_seq <= fec_seq) && (head_seq > low_bound);

endmodule

// ===== rtl/core/ffrt_out_stage.sv =====
// Output stage: holds one result back so the final result of an item carries last.
module ffrt_out_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ffrt_pkg::prod_t       prod,
  output logic                  out_strobe,
  output logic [3:0]            out_kind,
  output logic [31:0]           out_frame_seq,
  output logic [31:0]           out_frame_time,
  output logic [7:0]            out_frame_parts,
  output logic                  out_is_key,
  output logic [15:0]           out_frame_rotation,
  output logic                  out_last
);
  import ffrt_pkg::*;

  logic hold_v_r;
  res_t hold_r;
  res_t send_r;

  // Control: strobe and hold occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r   <= 1'b0;
      out_strobe <= 1'b0;
      out_last   <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      out_last   <= 1'b0;
      if (prod.valid) begin
        out_strobe <= hold_v_r;
        hold_v_r   <= 1'b1;
      end else if (prod.flush && hold_v_r) begin
        out_strobe <= 1'b1;
        out_last   <= 1'b1;
        hold_v_r   <= 1'b0;
      end
    end
  end

  // Payload: the held result moves out, the new one takes its place.
  always_ff @(posedge clk) begin
    if (prod.valid) begin
      hold_r <= prod.res;
    end
    send_r <= hold_r;
  end

  assign out_kind           = send_r.kind;
  assign out_frame_seq      = send_r.seq;
  assign out_frame_time     = send_r.ftime;
  assign out_frame_parts    = send_r.parts;
  assign out_is_key         = send_r.key;
  assign out_frame_rotation = send_r.rot;

endmodule

// ===== rtl/core/frame_fragment_reassembly_tracker.sv =====
// Top level of the frame fragment reassembly tracker: sequencer and pending state.
//
// Usage: drive an item on the in_ ports with start high; it is taken at the
// rising edge where start is high and busy is low. busy then stays high until
// the last result of the item has been formed; that result is on the out_ ports
// in the first cycle after busy falls. op selects fragment or FEC record.
// Results appear on the out_ ports for one cycle each, marked by out_strobe,
// with out_last high on the final result of the item. The receiver cannot
// stall; every strobe must be taken.
// Steps: a fragment is matched by walking the pending frames in order; one
// with no match is a new frame, screened and, if accepted, allocated; then each
// released, lost or FEC-dropped head and each FEC record compared takes its own
// step, and an FEC search that finds nothing ends in a step of its own. An FEC
// record is checked against the held head, then stored. A result leaves only once
// the next result of the item is formed or the item ends, as one is held to mark the last.
// Reset (synchronous, rst_n low) empties the pending list and the FEC store and
// clears the last sequence number; no clearing pass is needed, since a slot's
// seen map row is rewritten whole when the slot is allocated.
module frame_fragment_reassembly_tracker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [7:0]  in_fragment_index,
  input  logic [15:0] in_fragment_count,
  input  logic [31:0] in_timestamp,
  input  logic [7:0]  in_seq_low,
  input  logic        in_keyframe,
  input  logic [15:0] in_rotation,
  input  logic [7:0]  in_fec_span,
  output logic        out_strobe,
  output logic [3:0]  out_kind,
  output logic [31:0] out_frame_seq,
  output logic [31:0] out_frame_time,
  output logic [7:0]  out_frame_parts,
  output logic        out_is_key,
  output logic [15:0] out_frame_rotation,
  output logic        out_last
);
  import ffrt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SEEN,
    ST_NEW,
    ST_REL,
    ST_FSRCH,
    ST_FCHK,
    ST_FSTORE,
    ST_FLUSH
  } state_t;

  // Control state.
  state_t              state_r, state_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [SLOT_W-1:0]   head_r, head_nxt;
  logic [FLEN_W-1:0]   flen_r, flen_nxt;
  logic [FEC_W-1:0]    fhead_r, fhead_nxt;
  logic [31:0]         last_seq_r, last_seq_nxt;
  logic                await_r, await_nxt;
  logic [LEN_W-1:0]    i_r, i_nxt;
  logic [FLEN_W-1:0]   j_r, j_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;

  // Latched item.
  logic                op_r, op_nxt;
  logic [7:0]          idx_r, idx_nxt;
  logic [15:0]         cnt_r, cnt_nxt;
  logic [31:0]         ts_r, ts_nxt;
  logic                key_r, key_nxt;
  logic [15:0]         rot_r, rot_nxt;
  logic [7:0]          span_r, span_nxt;
  logic [31:0]         fseq_r, fseq_nxt;

  // Pending frames and FEC records.
  logic [31:0]         pend_time_r [SLOTS], pend_time_nxt [SLOTS];
  logic [31:0]         pend_seq_r  [SLOTS], pend_seq_nxt  [SLOTS];
  logic [7:0]          pend_total_r[SLOTS], pend_total_nxt[SLOTS];
  logic [7:0]          pend_recv_r [SLOTS], pend_recv_nxt [SLOTS];
  logic                pend_key_r  [SLOTS], pend_key_nxt  [SLOTS];
  logic [15:0]         pend_rot_r  [SLOTS], pend_rot_nxt  [SLOTS];
  logic [31:0]         fec_seq_r   [FEC_RECORDS], fec_seq_nxt [FEC_RECORDS];
  logic [7:0]          fec_span_r  [FEC_RECORDS], fec_span_nxt[FEC_RECORDS];

  // Datapath signals.
  logic [SLOT_W-1:0]   srch_slot, tail_slot, head_step, rd_slot;
  logic [FEC_W-1:0]    fec_j_idx, fec_tail, fhead_step;
  logic [31:0]         frag_fseq, fec_fseq;
  res_t                slot_res;
  logic [7:0]          hd_total, hd_recv;
  logic [31:0]         cov_fseq;
  logic [7:0]          cov_span;
  logic                cov_hit;
  logic                late;
  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr;
  logic [ROW_W-1:0]    ram_wdata, ram_rdata;
  prod_t               prod;

  assign busy = (state_r != ST_IDLE);

  // Ring positions.
  assign srch_slot  = slot_ring(head_r, i_r);
  assign tail_slot  = slot_ring(head_r, len_r);
  assign head_step  = slot_ring(head_r, LEN_W'(1));
  assign fec_j_idx  = fec_ring(fhead_r, j_r);
  assign fec_tail   = fec_ring(fhead_r, flen_r);
  assign fhead_step = fec_ring(fhead_r, FLEN_W'(1));

  // Sequence extension against the last accepted frame.
  assign fec_fseq  = {last_seq_r[31:8], in_seq_low};
  assign frag_fseq = (last_seq_r[7:0] > in_seq_low) ?
                     {last_seq_r[31:8] + 24'd1, in_seq_low} : fec_fseq;

  // Slot whose stored fields a result reports.
  always_comb begin
    unique case (state_r)
      ST_SRCH: rd_slot = srch_slot;
      ST_SEEN: rd_slot = slot_r;
      default: rd_slot = head_r;
    endcase
  end

  always_comb begin
    slot_res.kind  = KIND_ADDED;
    slot_res.seq   = pend_seq_r[rd_slot];
    slot_res.ftime = pend_time_r[rd_slot];
    slot_res.parts = pend_total_r[rd_slot];
    slot_res.key   = pend_key_r[rd_slot];
    slot_res.rot   = pend_rot_r[rd_slot];
  end

  assign hd_total = pend_total_r[head_r];
  assign hd_recv  = pend_recv_r[head_r];
  assign late     = (last_seq_r > 32'd3) && (fseq_r < (last_seq_r - 32'd3));

  // Shared cover compare: stored records while searching, else the new record.
  assign cov_fseq = (state_r == ST_FSRCH) ? fec_seq_r[fec_j_idx] : fseq_r;
  assign cov_span = (state_r == ST_FSRCH) ? fec_span_r[fec_j_idx] : span_r;

  ffrt_cover u_cover (
    .head_seq (pend_seq_r[head_r]),
    .fec_seq  (cov_fseq),
    .fec_span (cov_span),
    .hit      (cov_hit)
  );

  // Seen maps, one row per physical slot.
  ffrt_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SLOTS)
  ) u_seen_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (srch_slot),
    .rdata (ram_rdata)
  );

  // Sequencer.
  always_comb begin
    state_nxt    = state_r;
    len_nxt      = len_r;
    head_nxt     = head_r;
    flen_nxt     = flen_r;
    fhead_nxt    = fhead_r;
    last_seq_nxt = last_seq_r;
    await_nxt    = await_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    slot_nxt     = slot_r;
    op_nxt       = op_r;
    idx_nxt      = idx_r;
    cnt_nxt      = cnt_r;
    ts_nxt       = ts_r;
    key_nxt      = key_r;
    rot_nxt      = rot_r;
    span_nxt     = span_r;
    fseq_nxt     = fseq_r;
    pend_time_nxt  = pend_time_r;
    pend_seq_nxt   = pend_seq_r;
    pend_total_nxt = pend_total_r;
    pend_recv_nxt  = pend_recv_r;
    pend_key_nxt   = pend_key_r;
    pend_rot_nxt   = pend_rot_r;
    fec_seq_nxt    = fec_seq_r;
    fec_span_nxt   = fec_span_r;
    ram_we       = 1'b0;
    ram_waddr    = slot_r;
    ram_wdata    = ram_rdata;
    prod.valid   = 1'b0;
    prod.flush   = 1'b0;
    prod.res     = slot_res;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt   = in_op;
          idx_nxt  = in_fragment_index;
          cnt_nxt  = in_fragment_count;
          ts_nxt   = in_timestamp;
          key_nxt  = in_keyframe;
          rot_nxt  = in_rotation;
          span_nxt = in_fec_span;
          fseq_nxt = in_op ? fec_fseq : frag_fseq;
          i_nxt    = '0;
          state_nxt = in_op ? ST_FCHK : ST_SRCH;
        end
      end

      // Look for the pending frame with this timestamp, one slot a cycle.
      ST_SRCH: begin
        if (i_r == len_r) begin
          state_nxt = ST_NEW;
        end else if (pend_time_r[srch_slot] == ts_r) begin
          slot_nxt = srch_slot;
          if (cnt_r != {8'd0, pend_total_r[srch_slot]}) begin
            prod.valid    = 1'b1;
            prod.res.kind = KIND_MISMATCH;
            state_nxt     = ST_FLUSH;
          end else if (idx_r >= pend_total_r[srch_slot]) begin
            prod.valid    = 1'b1;
            prod.res.kind = KIND_INDEX_BAD;
            state_nxt     = ST_FLUSH;
          end else begin
            state_nxt = ST_SEEN;
          end
        end else begin
          i_nxt = i_r + LEN_W'(1);
        end
      end

      // Seen map row is back: mark the fragment, count it once.
      ST_SEEN: begin
        ram_we    = 1'b1;
        ram_waddr = slot_r;
        ram_wdata = ram_rdata | (ROW_W'(1) << idx_r);
        if (!ram_rdata[idx_r]) begin
          pend_recv_nxt[slot_r] = pend_recv_r[slot_r] + 8'd1;
        end
        prod.valid    = 1'b1;
        prod.res.kind = KIND_ADDED;
        state_nxt     = ST_FLUSH;
      end

      // New frame: screen it, then allocate the tail slot.
      ST_NEW: begin
        prod.valid     = 1'b1;
        prod.res.seq   = fseq_r;
        prod.res.ftime = ts_r;
        prod.res.parts = '0;
        prod.res.key   = 1'b0;
        prod.res.rot   = '0;
        state_nxt      = ST_FLUSH;
        if (late) begin
          prod.res.kind = KIND_LATE;
        end else if ({8'd0, idx_r} >= cnt_r) begin
          prod.res.kind = KIND_INDEX_BAD;
        end else if (cnt_r > 16'(MAX_PARTS)) begin
          prod.res.kind = KIND_COUNT_BIG;
        end else if (32'(len_r) >= 32'(SLOTS)) begin
          prod.res.kind = KIND_LATE;
        end else begin
          pend_time_nxt[tail_slot]  = ts_r;
          pend_seq_nxt[tail_slot]   = fseq_r;
          pend_total_nxt[tail_slot] = cnt_r[7:0];
          pend_recv_nxt[tail_slot]  = 8'd1;
          pend_key_nxt[tail_slot]   = key_r;
          pend_rot_nxt[tail_slot]   = rot_r;
          ram_we         = 1'b1;
          ram_waddr      = tail_slot;
          ram_wdata      = ROW_W'(1) << idx_r;
          len_nxt        = len_r + LEN_W'(1);
          prod.res.kind  = KIND_NEW;
          prod.res.parts = cnt_r[7:0];
          prod.res.key   = key_r;
          prod.res.rot   = rot_r;
          state_nxt      = ST_REL;
        end
      end

      // Release, drop or hold head frames while the window is exceeded.
      ST_REL: begin
        if (32'(len_r) > 32'(WINDOW)) begin
          if (hd_recv == hd_total) begin
            prod.valid    = 1'b1;
            prod.res.kind = KIND_RELEASED;
            head_nxt      = head_step;
            len_nxt       = len_r - LEN_W'(1);
          end else if ((hd_total - hd_recv) == 8'd1 && !await_r) begin
            j_nxt     = '0;
            state_nxt = ST_FSRCH;
          end else begin
            await_nxt     = 1'b0;
            prod.valid    = 1'b1;
            prod.res.kind = KIND_LOST;
            head_nxt      = head_step;
            len_nxt       = len_r - LEN_W'(1);
          end
        end else begin
          last_seq_nxt = fseq_r;
          state_nxt    = ST_FLUSH;
        end
      end

      // Search the stored FEC records for one covering the head.
      ST_FSRCH: begin
        if (j_r == flen_r) begin
          await_nxt    = 1'b1;
          last_seq_nxt = fseq_r;
          state_nxt    = ST_FLUSH;
        end else if (cov_hit) begin
          prod.valid    = 1'b1;
          prod.res.kind = KIND_FEC_DROP;
          head_nxt      = head_step;
          len_nxt       = len_r - LEN_W'(1);
          state_nxt     = ST_REL;
        end else begin
          j_nxt = j_r + FLEN_W'(1);
        end
      end

      // A new FEC record may discard a held head.
      ST_FCHK: begin
        if (await_r && (len_r != '0) && cov_hit) begin
          prod.valid    = 1'b1;
          prod.res.kind = KIND_FEC_DROP;
          head_nxt      = head_step;
          len_nxt       = len_r - LEN_W'(1);
          await_nxt     = 1'b0;
        end
        state_nxt = ST_FSTORE;
      end

      // Store the record, overwriting the oldest when full.
      ST_FSTORE: begin
        fec_seq_nxt[fec_tail]  = fseq_r;
        fec_span_nxt[fec_tail] = span_r;
        if (32'(flen_r) == 32'(FEC_RECORDS)) begin
          fhead_nxt = fhead_step;
        end else begin
          flen_nxt = flen_r + FLEN_W'(1);
        end
        prod.valid     = 1'b1;
        prod.res.kind  = KIND_FEC_STORE;
        prod.res.seq   = fseq_r;
        prod.res.ftime = '0;
        prod.res.parts = '0;
        prod.res.key   = 1'b0;
        prod.res.rot   = '0;
        state_nxt      = ST_FLUSH;
      end

      ST_FLUSH: begin
        prod.flush = 1'b1;
        state_nxt  = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      len_r      <= '0;
      head_r     <= '0;
      flen_r     <= '0;
      fhead_r    <= '0;
      last_seq_r <= '0;
      await_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      len_r      <= len_nxt;
      head_r     <= head_nxt;
      flen_r     <= flen_nxt;
      fhead_r    <= fhead_nxt;
      last_seq_r <= last_seq_nxt;
      await_r    <= await_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    slot_r <= slot_nxt;
    op_r   <= op_nxt;
    idx_r  <= idx_nxt;
    cnt_r  <= cnt_nxt;
    ts_r   <= ts_nxt;
    key_r  <= key_nxt;
    rot_r  <= rot_nxt;
    span_r <= span_nxt;
    fseq_r <= fseq_nxt;
    pend_time_r  <= pend_time_nxt;
    pend_seq_r   <= pend_seq_nxt;
    pend_total_r <= pend_total_nxt;
    pend_recv_r  <= pend_recv_nxt;
    pend_key_r   <= pend_key_nxt;
    pend_rot_r   <= pend_rot_nxt;
    fec_seq_r    <= fec_seq_nxt;
    fec_span_r   <= fec_span_nxt;
  end

  ffrt_out_stage u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .prod               (prod),
    .out_strobe         (out_strobe),
    .out_kind           (out_kind),
    .out_frame_seq      (out_frame_seq),
    .out_frame_time     (out_frame_time),
    .out_frame_parts    (out_frame_parts),
    .out_is_key         (out_is_key),
    .out_frame_rotation (out_frame_rotation),
    .out_last           (out_last)
  );

endmodule
